// ===== rtl/core/hdlcd_pkg.sv =====
package hdlcd_pkg;

  localparam logic [7:0] FLAG_BYTE   = 8'h7E;
  localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
  localparam logic [7:0] ESCAPE_XOR  = 8'h20;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h8408;
  localparam int FCS_BYTES           = 2;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef enum logic [2:0] {
    STATUS_GOOD      = 3'd0,
    STATUS_CRC_ERROR = 3'd1,
    STATUS_TOO_SHORT = 3'd2,
    STATUS_ABORTED   = 3'd3,
    STATUS_OVERFLOW  = 3'd4
  } status_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] payload_byte;
    status_t    status;
    logic [7:0] length;
  } result_t;

  // Reflected CRC-16/X-25 update over one byte, least significant bit first.
  function automatic logic [15:0] crc_x25_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/hdlcd_rx_if.sv =====
interface hdlcd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/hdlcd_res_if.sv =====
interface hdlcd_res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [2:0] frame_status;
  logic [7:0] payload_length;

  modport source (
    output valid, output kind, output payload_byte, output frame_status,
    output payload_length, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input frame_status,
    input payload_length, output ready
  );
endinterface

// ===== rtl/core/hdlc_async_deframer_crc16.sv =====
// Asynchronous HDLC deframer with CRC-16/X-25 frame check.
// The rx channel takes one raw serial byte per transaction. Flags (0x7E) delimit
// frames, the escape 0x7D marks the next byte, which is XORed with 0x20.
// The res channel gives one transaction per payload byte (kind 0) and one per
// closed non-empty frame (kind 1) with the payload length and a status:
// good, CRC error, too short, aborted or overflow. Payload bytes trail the
// line by two unstuffed bytes, so the FCS itself is never delivered.
// A result becomes valid on res once its accepted byte has moved from the input
// register into the result register.
// Throughput: one byte per cycle while res is not stalled; the frame state, the
// byte-wise CRC update and the status decision all sit between those two registers.
// Bytes that produce no result (escapes, empty flags, overflow drops) still
// pass through the pipeline and leave res idle for that slot.
// When res is stalled, the result register holds its transaction and the
// input register holds one more byte; rx ready then drops until res moves.
// Reset clears the frame state, the CRC register and both pipeline valid flags.
// MAX_RECEIVE_UNIT sets how many unstuffed bytes a frame may hold.
module hdlc_async_deframer_crc16
  import hdlcd_pkg::*;
#(
  parameter int MAX_RECEIVE_UNIT = 256
) (
  input logic        clk,
  input logic        rst,
  hdlcd_rx_if.sink   rx,
  hdlcd_res_if.source res
);

  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;
  logic       fire;
  result_t    core_result;
  result_t    out_reg;

  assign advance  = !out_reg.valid || res.ready;
  assign fire     = in_full && advance;
  assign rx.ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rx.ready) begin
      in_full <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  hdlcd_core #(
    .MAX_RECEIVE_UNIT(MAX_RECEIVE_UNIT)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .byte_in(in_byte),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg.valid <= 1'b0;
    end else if (advance) begin
      out_reg.valid <= fire && core_result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_reg.kind         <= core_result.kind;
      out_reg.payload_byte <= core_result.payload_byte;
      out_reg.status       <= core_result.status;
      out_reg.length       <= core_result.length;
    end
  end

  assign res.valid          = out_reg.valid;
  assign res.kind           = out_reg.kind;
  assign res.payload_byte   = out_reg.payload_byte;
  assign res.frame_status   = out_reg.status;
  assign res.payload_length = out_reg.length;

endmodule

// ===== rtl/core/hdlcd_core.sv =====
module hdlcd_core
  import hdlcd_pkg::*;
#(
  parameter int MAX_RECEIVE_UNIT = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] byte_in,
  output result_t    result
);

  localparam int CW = $clog2(MAX_RECEIVE_UNIT + 1);
  localparam int LW = (CW > 8) ? CW : 8;

  logic          escape_pending;
  logic [CW-1:0] byte_count;
  logic [7:0]    older_held_byte;
  logic [7:0]    newer_held_byte;
  logic [15:0]   running_crc;
  logic          overflowed;

  logic          is_flag;
  logic          is_escape;
  logic          frame_empty;
  logic [7:0]    data_byte;
  logic          take_data;
  logic          at_limit;
  logic          release_byte;
  logic [15:0]   fcs;
  logic [LW-1:0] len_wide;
  logic [7:0]    len_sat;
  status_t       end_status;

  assign is_flag      = (byte_in == FLAG_BYTE);
  assign is_escape    = (byte_in == ESCAPE_BYTE);
  assign frame_empty  = (byte_count == '0) && !escape_pending;
  assign data_byte    = escape_pending ? (byte_in ^ ESCAPE_XOR) : byte_in;
  assign take_data    = !is_flag && (escape_pending || !is_escape);
  assign at_limit     = (byte_count == CW'(MAX_RECEIVE_UNIT));
  assign release_byte = take_data && !at_limit && (byte_count >= CW'(FCS_BYTES));
  assign fcs          = running_crc ^ CRC_INIT;

  always_comb begin
    if (byte_count >= CW'(FCS_BYTES)) begin
      len_wide = LW'(byte_count) - LW'(FCS_BYTES);
    end else begin
      len_wide = '0;
    end
    if (len_wide > LW'(255)) begin
      len_sat = 8'hFF;
    end else begin
      len_sat = len_wide[7:0];
    end
  end

  always_comb begin
    if (escape_pending) begin
      end_status = STATUS_ABORTED;
    end else if (overflowed) begin
      end_status = STATUS_OVERFLOW;
    end else if (byte_count < CW'(FCS_BYTES)) begin
      end_status = STATUS_TOO_SHORT;
    end else if (older_held_byte == fcs[7:0] && newer_held_byte == fcs[15:8]) begin
      end_status = STATUS_GOOD;
    end else begin
      end_status = STATUS_CRC_ERROR;
    end
  end

  always_comb begin
    result.valid        = 1'b0;
    result.kind         = KIND_DATA;
    result.payload_byte = 8'h00;
    result.status       = STATUS_GOOD;
    result.length       = 8'h00;
    if (is_flag) begin
      if (!frame_empty) begin
        result.valid  = 1'b1;
        result.kind   = KIND_END;
        result.status = end_status;
        result.length = len_sat;
      end
    end else if (release_byte) begin
      result.valid        = 1'b1;
      result.payload_byte = older_held_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending  <= 1'b0;
      byte_count      <= '0;
      older_held_byte <= 8'h00;
      newer_held_byte <= 8'h00;
      running_crc     <= CRC_INIT;
      overflowed      <= 1'b0;
    end else if (fire) begin
      if (is_flag) begin
        escape_pending  <= 1'b0;
        byte_count      <= '0;
        older_held_byte <= 8'h00;
        newer_held_byte <= 8'h00;
        running_crc     <= CRC_INIT;
        overflowed      <= 1'b0;
      end else if (!take_data) begin
        escape_pending <= 1'b1;
      end else begin
        escape_pending <= 1'b0;
        if (at_limit) begin
          overflowed <= 1'b1;
        end else begin
          if (release_byte) begin
            running_crc <= crc_x25_byte(running_crc, older_held_byte);
          end
          older_held_byte <= newer_held_byte;
          newer_held_byte <= data_byte;
          byte_count      <= byte_count + CW'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/core/hdlcd_checker.sv =====
module hdlcd_checker
  import hdlcd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic       kind,
  input logic [7:0] payload_byte,
  input logic [2:0] frame_status,
  input logic [7:0] payload_length
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("A stalled result transaction was withdrawn.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("A result transaction appeared right after reset.");

  a_end_no_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_END |-> payload_byte == 8'h00)
    else $error("An end of frame carried a payload byte.");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_DATA |-> frame_status == STATUS_GOOD && payload_length == 8'h00)
    else $error("A data byte carried frame status or length.");

  a_short_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_END && frame_status == STATUS_TOO_SHORT
      |-> payload_length == 8'h00)
    else $error("A too short frame reported a nonzero length.");

endmodule

bind hdlc_async_deframer_crc16 hdlcd_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .kind          (res.kind),
  .payload_byte  (res.payload_byte),
  .frame_status  (res.frame_status),
  .payload_length(res.payload_length)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import hdlcd_pkg::*;

  localparam int MRU = 256;

  typedef logic [7:0] octet_q_t[$];

  typedef struct {
    logic       kind;
    logic [7:0] payload_byte;
    status_t    status;
    logic [7:0] length;
  } deframed_out_t;

  logic clk = 1'b0;
  logic rst;

  hdlcd_rx_if rx_ch();
  hdlcd_res_if res_ch();

  hdlc_async_deframer_crc16 #(
    .MAX_RECEIVE_UNIT(MRU)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .rx(rx_ch),
    .res(res_ch)
  );

  always #5 clk = ~clk;

  deframed_out_t awaited_outputs[$];
  int mismatches = 0;
  int rx_items_sent = 0;
  int idle_pct = 0;

  bit         esc_seen;
  int         frame_bytes;
  logic [7:0] delay_old;
  logic [7:0] delay_new;
  logic [15:0] frame_crc;
  bit         mru_exceeded;

  function automatic logic [15:0] x25_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void restart_frame();
    esc_seen = 1'b0;
    frame_bytes = 0;
    delay_old = 8'h00;
    delay_new = 8'h00;
    frame_crc = CRC_INIT;
    mru_exceeded = 1'b0;
  endfunction

  function automatic void deframe_rx_byte(input logic [7:0] raw);
    logic [7:0] b;
    deframed_out_t r;
    int kept;
    logic [15:0] fcs;
    b = raw;
    if (raw == FLAG_BYTE) begin
      if (frame_bytes != 0 || esc_seen) begin
        kept = (frame_bytes >= FCS_BYTES) ? frame_bytes - FCS_BYTES : 0;
        if (kept > 255) begin
          kept = 255;
        end
        fcs = ~frame_crc;
        r.kind = KIND_END;
        r.payload_byte = 8'h00;
        r.length = 8'(kept);
        if (esc_seen) begin
          r.status = STATUS_ABORTED;
        end else if (mru_exceeded) begin
          r.status = STATUS_OVERFLOW;
        end else if (frame_bytes < FCS_BYTES) begin
          r.status = STATUS_TOO_SHORT;
        end else if (delay_old == fcs[7:0] && delay_new == fcs[15:8]) begin
          r.status = STATUS_GOOD;
        end else begin
          r.status = STATUS_CRC_ERROR;
        end
        awaited_outputs.push_back(r);
      end
      restart_frame();
      return;
    end
    if (esc_seen) begin
      esc_seen = 1'b0;
      b = raw ^ ESCAPE_XOR;
    end else if (raw == ESCAPE_BYTE) begin
      esc_seen = 1'b1;
      return;
    end
    if (frame_bytes >= MRU) begin
      mru_exceeded = 1'b1;
      return;
    end
    if (frame_bytes >= FCS_BYTES) begin
      frame_crc = x25_step(frame_crc, delay_old);
      r.kind = KIND_DATA;
      r.payload_byte = delay_old;
      r.status = STATUS_GOOD;
      r.length = 8'h00;
      awaited_outputs.push_back(r);
    end
    delay_old = delay_new;
    delay_new = b;
    frame_bytes++;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : res_watch
    deframed_out_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (awaited_outputs.size() == 0) begin
        $display("%0t: extra result, expected none, actual %0d %h %0d %0d",
                 $time, res_ch.kind, res_ch.payload_byte, res_ch.frame_status,
                 res_ch.payload_length);
        mismatches++;
      end else begin
        want = awaited_outputs.pop_front();
        check_field("kind", 8'(want.kind), 8'(res_ch.kind));
        check_field("payload_byte", want.payload_byte, res_ch.payload_byte);
        check_field("frame_status", 8'(want.status), 8'(res_ch.frame_status));
        check_field("payload_length", want.length, res_ch.payload_length);
      end
    end
  end

  initial begin : res_ready_driver
    int stall_left;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 399) < idle_pct) begin
        stall_left = $urandom_range(1, 18) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_rx_byte(input logic [7:0] b);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    deframe_rx_byte(b);
    rx_items_sent++;
  endtask

  task automatic send_stuffed(input logic [7:0] b);
    if (b == FLAG_BYTE || b == ESCAPE_BYTE ||
        (b != (FLAG_BYTE ^ ESCAPE_XOR) && $urandom_range(0, 9) == 0)) begin
      send_rx_byte(ESCAPE_BYTE);
      send_rx_byte(b ^ ESCAPE_XOR);
    end else begin
      send_rx_byte(b);
    end
  endtask

  task automatic send_fcs(input octet_q_t body, input bit bad_fcs);
    logic [15:0] crc;
    crc = CRC_INIT;
    foreach (body[i]) begin
      crc = x25_step(crc, body[i]);
    end
    crc = ~crc;
    if (bad_fcs) begin
      crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    end
    send_stuffed(crc[7:0]);
    send_stuffed(crc[15:8]);
  endtask

  task automatic send_frame(input octet_q_t body, input bit open_flag, input bit bad_fcs,
                            input bit abort_end);
    if (open_flag) begin
      send_rx_byte(FLAG_BYTE);
    end
    foreach (body[i]) begin
      send_stuffed(body[i]);
    end
    send_fcs(body, bad_fcs);
    if (abort_end) begin
      send_rx_byte(ESCAPE_BYTE);
    end
    send_rx_byte(FLAG_BYTE);
  endtask

  function automatic logic [7:0] random_line_byte();
    logic [7:0] picks[4];
    picks = '{FLAG_BYTE, ESCAPE_BYTE, FLAG_BYTE ^ ESCAPE_XOR, ESCAPE_BYTE ^ ESCAPE_XOR};
    if ($urandom_range(0, 5) == 0) begin
      return picks[$urandom_range(0, 3)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic drain_results();
    rx_ch.valid <= 1'b0;
    while (awaited_outputs.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic test_special_frames();
    octet_q_t body;
    idle_pct = 0;
    send_rx_byte(FLAG_BYTE);
    send_rx_byte(FLAG_BYTE);
    send_rx_byte(8'h41);
    send_rx_byte(FLAG_BYTE);
    send_rx_byte(ESCAPE_BYTE);
    send_rx_byte(FLAG_BYTE);
    send_rx_byte(8'h41);
    send_rx_byte(ESCAPE_BYTE);
    send_rx_byte(FLAG_BYTE);
    body = {};
    send_frame(body, 1'b0, 1'b0, 1'b0);
    body = {FLAG_BYTE, ESCAPE_BYTE, 8'h00, 8'hFF};
    send_frame(body, 1'b0, 1'b0, 1'b0);
    body = {8'hA5};
    send_frame(body, 1'b0, 1'b1, 1'b0);
    send_rx_byte(ESCAPE_BYTE);
    send_rx_byte(ESCAPE_BYTE);
    body = {ESCAPE_BYTE ^ ESCAPE_XOR};
    send_fcs(body, 1'b0);
    send_rx_byte(FLAG_BYTE);
  endtask

  task automatic test_max_receive_unit();
    octet_q_t body;
    idle_pct = 5;
    body = {};
    repeat (MRU - FCS_BYTES) body.push_back(random_line_byte());
    send_frame(body, 1'b1, 1'b0, 1'b0);
    body.push_back(8'h3C);
    send_frame(body, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_drain_pause();
    octet_q_t body;
    idle_pct = 40;
    repeat (3) begin
      body = {};
      repeat ($urandom_range(0, 8)) body.push_back(random_line_byte());
      send_frame(body, 1'b1, 1'b0, 1'b0);
    end
    drain_results();
  endtask

  task automatic test_random_frames(input int item_target, input bit with_idling);
    octet_q_t body;
    int start;
    int pick;
    int len;
    bit paused;
    start = rx_items_sent;
    paused = 1'b0;
    while (rx_items_sent - start < item_target) begin
      if (!with_idling) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 8;
          default: idle_pct = 30;
        endcase
      end
      body = {};
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
      repeat (len) body.push_back(random_line_byte());
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(body, 1'b1, $urandom_range(0, 6) == 0, $urandom_range(0, 14) == 0);
      end else if (pick < 78) begin
        send_frame(body, 1'b0, $urandom_range(0, 6) == 0, 1'b0);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 6)) send_rx_byte(random_line_byte());
      end else begin
        send_rx_byte(FLAG_BYTE);
        repeat ($urandom_range(0, 2)) send_stuffed(random_line_byte());
        send_rx_byte(FLAG_BYTE);
      end
      if (with_idling && !paused && rx_items_sent - start > item_target / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    rx_ch.valid <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    restart_frame();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_special_frames();
    test_max_receive_unit();
    test_drain_pause();
    test_random_frames(200, 1'b1);
    test_random_frames(60, 1'b0);
    drain_results();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
